// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks with active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define TEFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds at the next clock edge after the antecedent
`define TEFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tefa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefa_pkg
// shared constants, types and fixed-point helpers of the triangle element
// force assembly block
// ----------------------------------------------------------------------------
package tefa_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ELEM = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam int DIV_BITS = 48;
    localparam int DIV_CNT_W = 6;

    localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'(INT32_MAX)) begin
            r = INT32_MAX;
        end else if (v < 68'(INT32_MIN)) begin
            r = INT32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // divide by 2^16, rounding toward zero
    function automatic logic signed [49:0] qtrunc(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + (p[65] ? 66'sd65535 : 66'sd0);
        return t[65:16];
    endfunction

endpackage

// ===== src/tefa_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefa channel interfaces
// command word channel and result word channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tefa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic [9:0]         node_c;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        elastic_modulus;
    logic [14:0]        poisson_ratio;

    modport source (
        output valid, command, node_a, node_b, node_c, pos_x, pos_y, vel_x, vel_y,
               elastic_modulus, poisson_ratio,
        input  ready
    );
    modport sink (
        input  valid, command, node_a, node_b, node_c, pos_x, pos_y, vel_x, vel_y,
               elastic_modulus, poisson_ratio,
        output ready
    );
endinterface

interface tefa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               fault;

    modport source (
        output valid, force_x, force_y, fault,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, fault,
        output ready
    );
endinterface

// ===== src/tefa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tefa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tefa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefa_mul
// shared signed multiplier with registered product and q16.16 saturating
// result
// ----------------------------------------------------------------------------
module tefa_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod,
    output logic signed [31:0] o_q
);

    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_a) * 66'(i_b);
    end

    assign o_prod = r_prod;
    assign o_q    = tefa_pkg::sat32(68'(tefa_pkg::qtrunc(r_prod)));

endmodule

// ===== src/tefa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefa_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tefa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tefa_pkg::DIV_BITS-1:0]     i_dividend,
    input  logic [31:0]                       i_divisor,
    output logic [tefa_pkg::DIV_BITS-1:0]     o_quotient,
    output tefa_pkg::t_div_stat               o_stat
);

    logic [tefa_pkg::DIV_BITS-1:0]  r_quo;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_div;
    logic [tefa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[tefa_pkg::DIV_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = !w_diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tefa_pkg::DIV_CNT_W'(tefa_pkg::DIV_BITS);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_quo <= {r_quo[tefa_pkg::DIV_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tefa_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/triangle_element_force_assembly_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_element_force_assembly_top
// constant strain triangle force assembly over node tables, q16.16
// ----------------------------------------------------------------------------
// One word at a time. After reset the force tables are cleared entry by
// entry before the first word is taken. Every word first reduces its node
// indices; a load then passes through S_LOAD and S_OUT, and a read through
// S_RDF, S_RDF2 and S_OUT. An element uses the single shared multiplier
// for 222 products, and the bit-serial divider for 2^32/det and, when the
// denominator is positive, for the material cofactor.
// A degenerate triangle ends after the determinant with the fault flag.
// The result word sits in an output register, so the next word is taken
// while it waits.
`include "assert_macros.svh"

module triangle_element_force_assembly_top #(
    parameter int NODE_COUNT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tefa_in_if.sink     i_in,
    tefa_out_if.source  o_out
);

    localparam int AW = $clog2(NODE_COUNT);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRAP, S_LOAD, S_RDF, S_RDF2, S_FETCH, S_DIFF,
        S_DET, S_DETF, S_INV, S_BM, S_NU, S_COF, S_CWAIT, S_D, S_BD, S_KF,
        S_FRD, S_FWR, S_OUT
    } t_state;

    t_state r_state;

    logic [1:0]         r_cmd;
    logic [9:0]         r_ia, r_ib, r_ic;
    logic [3:0]         r_wk;
    logic [1:0]         r_cnt;
    logic [AW-1:0]      r_cc;
    logic signed [31:0] r_ld_px, r_ld_py, r_ld_vx, r_ld_vy;
    logic [30:0]        r_e;
    logic [14:0]        r_nu;
    logic signed [31:0] r_px [3];
    logic signed [31:0] r_py [3];
    logic signed [31:0] r_vx [3];
    logic signed [31:0] r_vy [3];
    logic signed [31:0] r_x12, r_x13, r_x23, r_y12, r_y13, r_y23;
    logic signed [65:0] r_dacc;
    logic signed [31:0] r_det, r_inv, r_cof;
    logic signed [33:0] r_den;
    logic signed [31:0] r_bm [3][6];
    logic signed [31:0] r_d11, r_d12, r_d33;
    logic signed [31:0] r_bd [6][3];
    logic signed [31:0] r_f [6];
    logic signed [31:0] r_kv;
    logic signed [35:0] r_acc, r_facc;
    logic [2:0]         r_i, r_j;
    logic [1:0]         r_m;
    logic               r_ph;
    logic signed [31:0] r_res_fx, r_res_fy;
    logic               r_res_fault;
    logic signed [31:0] r_o_fx, r_o_fy;
    logic               r_o_fault;
    logic               r_ov;

    logic [9:0]         w_fnode, w_rnode;
    logic [31:0]        w_sh;
    logic signed [32:0] w_a, w_b, w_bs;
    logic signed [31:0] w_dsel, w_bmsel;
    logic [2:0]         w_bmcol;
    logic signed [65:0] w_prod;
    logic signed [31:0] w_q;
    logic signed [31:0] w_det;
    logic signed [35:0] w_sum, w_fsum;
    logic               w_div_start;
    logic [tefa_pkg::DIV_BITS-1:0] w_div_dvd, w_quo;
    logic [31:0]        w_div_dvs;
    tefa_pkg::t_div_stat w_div_stat;
    logic signed [49:0] w_qs;
    logic signed [31:0] w_pxr, w_pyr, w_vxr, w_vyr, w_fxr, w_fyr;
    logic               w_pv_we, w_f_we;
    logic [AW-1:0]      w_f_waddr;
    logic signed [31:0] w_f_wx, w_f_wy;

    // node selection for fetch and force access
    always_comb begin
        case (r_cnt)
            2'd0:    w_fnode = r_ia;
            2'd1:    w_fnode = r_ib;
            default: w_fnode = r_ic;
        endcase
        case (r_i)
            3'd0:    w_rnode = r_ia;
            3'd1:    w_rnode = r_ib;
            default: w_rnode = r_ic;
        endcase
    end

    assign w_sh = 32'(NODE_COUNT) << r_wk;

    // strain matrix source entries
    always_comb begin
        w_bs = '0;
        case (r_m)
            2'd0: begin
                case (r_i)
                    3'd0:    w_bs = 33'(r_y23);
                    3'd2:    w_bs = -33'(r_y13);
                    3'd4:    w_bs = 33'(r_y12);
                    default: w_bs = '0;
                endcase
            end
            2'd1: begin
                case (r_i)
                    3'd1:    w_bs = -33'(r_x23);
                    3'd3:    w_bs = 33'(r_x13);
                    3'd5:    w_bs = -33'(r_x12);
                    default: w_bs = '0;
                endcase
            end
            default: begin
                case (r_i)
                    3'd0:    w_bs = -33'(r_x23);
                    3'd1:    w_bs = 33'(r_y23);
                    3'd2:    w_bs = 33'(r_x13);
                    3'd3:    w_bs = -33'(r_y13);
                    3'd4:    w_bs = -33'(r_x12);
                    default: w_bs = 33'(r_y12);
                endcase
            end
        endcase
    end

    // material matrix entry d[m][j]
    always_comb begin
        w_dsel = '0;
        case (r_m)
            2'd0: w_dsel = (r_j == 3'd0) ? r_d11 : ((r_j == 3'd1) ? r_d12 : 32'sd0);
            2'd1: w_dsel = (r_j == 3'd0) ? r_d12 : ((r_j == 3'd1) ? r_d11 : 32'sd0);
            default: w_dsel = (r_j == 3'd2) ? r_d33 : 32'sd0;
        endcase
    end

    assign w_bmcol = (r_state == S_BD) ? r_i : r_j;
    assign w_bmsel = r_bm[r_m][w_bmcol];

    // shared multiplier operands
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_DET: begin
                w_a = (r_m == 2'd0) ? 33'(r_x13) : 33'(r_x23);
                w_b = (r_m == 2'd0) ? 33'(r_y23) : 33'(r_y13);
            end
            S_BM: begin
                w_a = w_bs;
                w_b = 33'(r_inv);
            end
            S_NU: begin
                w_a = 33'(r_nu);
                w_b = 33'(r_nu);
            end
            S_D: begin
                w_a = 33'(r_cof);
                case (r_m)
                    2'd0:    w_b = 33'sd65536 - 33'(r_nu);
                    2'd1:    w_b = 33'(r_nu);
                    default: w_b = 33'sd32768 - 33'(r_nu);
                endcase
            end
            S_BD: begin
                w_a = 33'(w_bmsel);
                w_b = 33'(w_dsel);
            end
            S_KF: begin
                if (r_m == 2'd3) begin
                    w_a = 33'(r_kv);
                    w_b = r_j[0] ? 33'(r_vy[r_j[2:1]]) : 33'(r_vx[r_j[2:1]]);
                end else begin
                    w_a = 33'(r_bd[r_i][r_m]);
                    w_b = 33'(w_bmsel);
                end
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    tefa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod),
        .o_q    (w_q)
    );

    assign w_det  = tefa_pkg::sat32(68'(tefa_pkg::qtrunc(r_dacc)));
    assign w_sum  = r_acc + 36'(w_q);
    assign w_fsum = r_facc + 36'(w_q);

    // divider requests
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dvs   = '0;
        if (r_state == S_DETF && w_det != 32'sd0) begin
            w_div_start = 1'b1;
            w_div_dvd   = tefa_pkg::DIV_BITS'(64'h1_0000_0000);
            w_div_dvs   = w_det[31] ? 32'(-33'(w_det)) : w_det;
        end else if (r_state == S_COF && r_den > 34'sd0) begin
            w_div_start = 1'b1;
            w_div_dvd   = tefa_pkg::DIV_BITS'({r_e, 16'd0});
            w_div_dvs   = r_den[31:0];
        end
    end

    tefa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    assign w_qs = (r_state == S_INV && r_det[31]) ? -50'($signed({2'b00, w_quo}))
                                                  : 50'($signed({2'b00, w_quo}));

    // node tables
    assign w_pv_we   = (r_state == S_LOAD);
    assign w_f_we    = (r_state == S_CLEAR) || (r_state == S_FWR);
    assign w_f_waddr = (r_state == S_CLEAR) ? r_cc : AW'(w_rnode);
    assign w_f_wx    = (r_state == S_CLEAR) ? 32'sd0
                     : tefa_pkg::sat32(68'(w_fxr) + 68'(r_f[{r_i[1:0], 1'b0}]));
    assign w_f_wy    = (r_state == S_CLEAR) ? 32'sd0
                     : tefa_pkg::sat32(68'(w_fyr) + 68'(r_f[{r_i[1:0], 1'b1}]));

    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_pos_x (
        .i_clk(i_clk), .i_we(w_pv_we), .i_waddr(AW'(r_ia)), .i_wdata(r_ld_px),
        .i_raddr(AW'(w_fnode)), .o_rdata(w_pxr)
    );
    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_pos_y (
        .i_clk(i_clk), .i_we(w_pv_we), .i_waddr(AW'(r_ia)), .i_wdata(r_ld_py),
        .i_raddr(AW'(w_fnode)), .o_rdata(w_pyr)
    );
    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_vel_x (
        .i_clk(i_clk), .i_we(w_pv_we), .i_waddr(AW'(r_ia)), .i_wdata(r_ld_vx),
        .i_raddr(AW'(w_fnode)), .o_rdata(w_vxr)
    );
    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_vel_y (
        .i_clk(i_clk), .i_we(w_pv_we), .i_waddr(AW'(r_ia)), .i_wdata(r_ld_vy),
        .i_raddr(AW'(w_fnode)), .o_rdata(w_vyr)
    );
    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_force_x (
        .i_clk(i_clk), .i_we(w_f_we), .i_waddr(w_f_waddr), .i_wdata(w_f_wx),
        .i_raddr(AW'(w_rnode)), .o_rdata(w_fxr)
    );
    tefa_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_force_y (
        .i_clk(i_clk), .i_we(w_f_we), .i_waddr(w_f_waddr), .i_wdata(w_f_wy),
        .i_raddr(AW'(w_rnode)), .o_rdata(w_fyr)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ov;
    assign o_out.force_x = r_o_fx;
    assign o_out.force_y = r_o_fy;
    assign o_out.fault   = r_o_fault;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cc    <= '0;
            r_ov    <= 1'b0;
            r_ph    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_cnt   <= '0;
            r_wk    <= '0;
        end else begin
            if (r_ov && o_out.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cc <= r_cc + 1'b1;
                    if (r_cc == AW'(NODE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd   <= i_in.command;
                        r_ia    <= i_in.node_a;
                        r_ib    <= i_in.node_b;
                        r_ic    <= i_in.node_c;
                        r_ld_px <= i_in.pos_x;
                        r_ld_py <= i_in.pos_y;
                        r_ld_vx <= i_in.vel_x;
                        r_ld_vy <= i_in.vel_y;
                        r_e     <= i_in.elastic_modulus;
                        r_nu    <= i_in.poisson_ratio;
                        r_wk    <= 4'd10;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_m     <= '0;
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if ({22'd0, r_ia} >= w_sh) r_ia <= r_ia - w_sh[9:0];
                    if ({22'd0, r_ib} >= w_sh) r_ib <= r_ib - w_sh[9:0];
                    if ({22'd0, r_ic} >= w_sh) r_ic <= r_ic - w_sh[9:0];
                    r_wk <= r_wk - 1'b1;
                    if (r_wk == 4'd0) begin
                        r_res_fx    <= '0;
                        r_res_fy    <= '0;
                        r_res_fault <= 1'b0;
                        case (r_cmd)
                            tefa_pkg::CMD_LOAD: r_state <= S_LOAD;
                            tefa_pkg::CMD_READ: r_state <= S_RDF;
                            tefa_pkg::CMD_ELEM: r_state <= S_FETCH;
                            default:            r_state <= S_OUT;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_OUT;
                end
                S_RDF: begin
                    r_state <= S_RDF2;
                end
                S_RDF2: begin
                    r_res_fx <= w_fxr;
                    r_res_fy <= w_fyr;
                    r_state  <= S_OUT;
                end
                S_FETCH: begin
                    if (r_cnt != 2'd0) begin
                        r_px[r_cnt - 2'd1] <= w_pxr;
                        r_py[r_cnt - 2'd1] <= w_pyr;
                        r_vx[r_cnt - 2'd1] <= w_vxr;
                        r_vy[r_cnt - 2'd1] <= w_vyr;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_x12 <= tefa_pkg::sat32(68'(r_px[0]) - 68'(r_px[1]));
                    r_x13 <= tefa_pkg::sat32(68'(r_px[0]) - 68'(r_px[2]));
                    r_x23 <= tefa_pkg::sat32(68'(r_px[1]) - 68'(r_px[2]));
                    r_y12 <= tefa_pkg::sat32(68'(r_py[0]) - 68'(r_py[1]));
                    r_y13 <= tefa_pkg::sat32(68'(r_py[0]) - 68'(r_py[2]));
                    r_y23 <= tefa_pkg::sat32(68'(r_py[1]) - 68'(r_py[2]));
                    r_m     <= '0;
                    r_state <= S_DET;
                end
                S_DET: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_m == 2'd0) begin
                            r_dacc <= w_prod;
                            r_m    <= 2'd1;
                        end else begin
                            r_dacc  <= r_dacc - w_prod;
                            r_m     <= '0;
                            r_state <= S_DETF;
                        end
                    end
                end
                S_DETF: begin
                    r_det <= w_det;
                    if (w_det == 32'sd0) begin
                        r_res_fault <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_INV;
                    end
                end
                S_INV: begin
                    if (w_div_stat.done) begin
                        r_inv   <= tefa_pkg::sat32(68'(w_qs));
                        r_i     <= '0;
                        r_m     <= '0;
                        r_state <= S_BM;
                    end
                end
                S_BM: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_bm[r_m][r_i] <= w_q;
                        if (r_i == 3'd5) begin
                            r_i <= '0;
                            if (r_m == 2'd2) begin
                                r_m     <= '0;
                                r_state <= S_NU;
                            end else begin
                                r_m <= r_m + 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_NU: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_den   <= 34'sd65536 - 34'(r_nu) - (34'(w_q) <<< 1);
                        r_state <= S_COF;
                    end
                end
                S_COF: begin
                    if (r_den > 34'sd0) begin
                        r_state <= S_CWAIT;
                    end else begin
                        r_cof   <= tefa_pkg::INT32_MAX;
                        r_m     <= '0;
                        r_state <= S_D;
                    end
                end
                S_CWAIT: begin
                    if (w_div_stat.done) begin
                        r_cof   <= tefa_pkg::sat32(68'(w_qs));
                        r_m     <= '0;
                        r_state <= S_D;
                    end
                end
                S_D: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        case (r_m)
                            2'd0:    r_d11 <= w_q;
                            2'd1:    r_d12 <= w_q;
                            default: r_d33 <= w_q;
                        endcase
                        if (r_m == 2'd2) begin
                            r_m     <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= S_BD;
                        end else begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                S_BD: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_m == 2'd2) begin
                            r_bd[r_i][r_j[1:0]] <= tefa_pkg::sat32(68'(w_sum));
                            r_acc <= '0;
                            r_m   <= '0;
                            if (r_j == 3'd2) begin
                                r_j <= '0;
                                if (r_i == 3'd5) begin
                                    r_i     <= '0;
                                    r_facc  <= '0;
                                    r_state <= S_KF;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_acc <= w_sum;
                            r_m   <= r_m + 1'b1;
                        end
                    end
                end
                S_KF: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_m == 2'd3) begin
                            r_m <= '0;
                            if (r_j == 3'd5) begin
                                r_f[r_i] <= tefa_pkg::sat32(68'(w_fsum));
                                r_facc   <= '0;
                                r_j      <= '0;
                                if (r_i == 3'd5) begin
                                    r_i     <= '0;
                                    r_state <= S_FRD;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end else begin
                                r_facc <= w_fsum;
                                r_j    <= r_j + 1'b1;
                            end
                        end else if (r_m == 2'd2) begin
                            r_kv  <= tefa_pkg::sat32(68'(w_sum));
                            r_acc <= '0;
                            r_m   <= 2'd3;
                        end else begin
                            r_acc <= w_sum;
                            r_m   <= r_m + 1'b1;
                        end
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (r_i == 3'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_o_fx    <= r_res_fx;
                        r_o_fy    <= r_res_fy;
                        r_o_fault <= r_res_fault;
                        r_ov      <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TEFA_ASSERT(a_div_start_idle, i_clk, i_rst_n, w_div_start |-> !w_div_stat.busy, "divider restarted while busy")
    `TEFA_ASSERT(a_fault_zero, i_clk, i_rst_n, (o_out.valid && o_out.fault) |-> (o_out.force_x == 32'sd0 && o_out.force_y == 32'sd0), "fault word carries force")
    `TEFA_ASSERT_NEXT(a_accept_wrap, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_WRAP, "accepted word did not start index reduction")

endmodule
